// ===== hdl/scu_pkg.sv =====
package scu_pkg;

   // Field types of the request and response words
   typedef logic [1:0]         opcode_type;
   typedef logic signed [31:0] angle_type;
   typedef logic signed [31:0] value_type;

   // Opcodes: bit 0 selects cosine, bit 1 selects degrees
   localparam opcode_type OP_SIN_RAD = 2'd0;
   localparam opcode_type OP_COS_RAD = 2'd1;
   localparam opcode_type OP_SIN_DEG = 2'd2;
   localparam opcode_type OP_COS_DEG = 2'd3;

   typedef struct packed {
      opcode_type opcode;
      angle_type  angle;
   } req_word_type;

   typedef struct packed {
      value_type value;
   } rsp_word_type;

   // Radian angle with 32 fraction bits, wide enough for any input
   typedef logic signed [48:0] rad_type;

   // Reduced angle in Q2.30, sign and magnitude
   typedef struct packed {
      logic        neg;
      logic [30:0] mag;
   } red_word_type;

   // Angle constants, 32 fraction bits (pi taken as 3.1415925)
   localparam logic [63:0] PI_Q32            = 64'd13493037045;
   localparam logic [63:0] TWO_PI_Q32        = PI_Q32 * 2;
   localparam logic [63:0] HALF_PI_Q32       = PI_Q32 / 2;
   localparam logic [63:0] THREE_HALF_PI_Q32 = (PI_Q32 * 3) / 2;
   localparam logic [63:0] DEG_TO_RAD_Q32    = PI_Q32 / 180;
   localparam logic [63:0] NINETY_Q16        = 64'd90 * 64'd65536;
   localparam logic [63:0] COS_DEG_OFFSET    = NINETY_Q16 * DEG_TO_RAD_Q32;

   // Reciprocal of 2pi scaled by 2^48, rounded
   localparam logic [63:0] RECIP_TWO_PI = ((64'd1 << 48) + TWO_PI_Q32 / 2) / TWO_PI_Q32;

   // Largest reduced magnitude after rounding to Q2.30
   localparam logic [63:0] MAG_MAX = (HALF_PI_Q32 + 2) >> 2;

   // Taylor coefficients in Q2.30, rounded to nearest
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [63:0] C3_Q30  = (ONE_Q30 + 3) / 6;
   localparam logic [63:0] C5_Q30  = (ONE_Q30 + 60) / 120;
   localparam logic [63:0] C7_Q30  = (ONE_Q30 + 2520) / 5040;
   localparam logic [63:0] C9_Q30  = (ONE_Q30 + 181440) / 362880;

   // Unsigned Q2.30 product, rounded half up on the magnitude
   function automatic logic [37:0] mul_q30(input logic [35:0] a, input logic [31:0] b);
      logic [67:0] p;
      p = 68'(a) * 68'(b) + (68'd1 << 29);
      return p[67:30];
   endfunction

endpackage

// ===== hdl/scu_if.sv =====
interface scu_if #(parameter type word_type = scu_pkg::rsp_word_type);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ===== hdl/sine_cosine_unit.sv =====
// Sine and cosine of a Q16.16 angle, result in Q2.30 clamped to [-1, 1].
// The request channel carries a word with opcode (bit 0 cosine, bit 1
// degrees) and angle; the response channel carries one word with value for
// every request, in request order. Both channels move a word at a rising
// clock edge where valid and ready are both high.
// From the accepting edge to the edge where the result can be taken, a word
// passes 3 stages that convert the angle to radians, 6 that reduce it to a
// quarter turn and 7 that evaluate the Taylor polynomial through x^9. The
// widest multiplier in any stage is 36 by 32 bits; no stage chains two.
// Throughput is one word per cycle while the response side is ready; a stage
// takes a new word each cycle while it is empty or the next one moves on.
// A stalled response holds its word; earlier stages keep taking words until
// every stage is full, so req ready falls only after 16 words wait.
// Reset clears the stage valid bits and drops any words in flight; there is
// no other control state and the block accepts a word in the first cycle after.
module sine_cosine_unit (
   input logic  clock,
   input logic  reset,
   scu_if.sink   req_chan,
   scu_if.source rsp_chan
);
   import scu_pkg::*;

   logic         ang_valid, ang_ready;
   rad_type      ang_x;
   logic         red_valid, red_ready;
   red_word_type red_word;

   // Convert the angle to radians
   scu_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_word   (req_chan.word),
      .out_valid (ang_valid),
      .out_ready (ang_ready),
      .out_x     (ang_x)
   );

   // Reduce to a quarter turn
   scu_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ang_valid),
      .in_ready  (ang_ready),
      .in_x      (ang_x),
      .out_valid (red_valid),
      .out_ready (red_ready),
      .out_word  (red_word)
   );

   // Evaluate the polynomial and clamp
   scu_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (red_valid),
      .in_ready  (red_ready),
      .in_word   (red_word),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_word  (rsp_chan.word)
   );

endmodule

// ===== hdl/scu_angle.sv =====
module scu_angle (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  scu_pkg::req_word_type in_word,
   output logic                 out_valid,
   input  logic                 out_ready,
   output scu_pkg::rad_type     out_x
);
   import scu_pkg::*;

   localparam int STAGES = 3;
   localparam logic signed [27:0] DegScale  = 28'(DEG_TO_RAD_Q32);
   localparam logic signed [59:0] HalfPi    = 60'(HALF_PI_Q32);
   localparam logic signed [59:0] CosDegOff = 60'(COS_DEG_OFFSET);

   logic [STAGES-1:0] v_ff, v_in, en;

   logic signed [31:0] angle_s;
   opcode_type         op1_ff;
   logic signed [31:0] ang1_ff;
   logic signed [59:0] prod1_ff, prod1_in;

   logic               is_cos, is_deg;
   logic signed [59:0] rad_base, base, offset;
   logic               deg2_ff;
   logic signed [59:0] raw2_ff, raw2_in;

   logic signed [59:0] rnd_sum;
   logic signed [43:0] deg_x;
   rad_type            x3_ff, x3_in;

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      v_in = v_ff;
      if (en[0]) begin
         v_in[0] = in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (en[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Stage 1: scale the angle as degrees
   assign angle_s  = in_word.angle;
   assign prod1_in = angle_s * DegScale;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         op1_ff   <= in_word.opcode;
         ang1_ff  <= angle_s;
         prod1_ff <= prod1_in;
      end
   end

   // Stage 2: pick the unit and add the quarter turn for cosine
   always_comb begin
      unique case (op1_ff)
         OP_SIN_RAD: begin
            is_cos = 1'b0;
            is_deg = 1'b0;
         end
         OP_COS_RAD: begin
            is_cos = 1'b1;
            is_deg = 1'b0;
         end
         OP_SIN_DEG: begin
            is_cos = 1'b0;
            is_deg = 1'b1;
         end
         OP_COS_DEG: begin
            is_cos = 1'b1;
            is_deg = 1'b1;
         end
         default: begin
            is_cos = 1'b0;
            is_deg = 1'b0;
         end
      endcase
   end

   assign rad_base = {{12{ang1_ff[31]}}, ang1_ff, 16'd0};
   assign base     = is_deg ? prod1_ff : rad_base;
   assign offset   = !is_cos ? 60'sd0 : (is_deg ? CosDegOff : HalfPi);
   assign raw2_in  = base + offset;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         deg2_ff <= is_deg;
         raw2_ff <= raw2_in;
      end
   end

   // Stage 3: round the degree product to 32 fraction bits, half away from zero
   assign rnd_sum = raw2_ff + (raw2_ff[59] ? 60'sd32767 : 60'sd32768);
   assign deg_x   = rnd_sum[59:16];
   assign x3_in   = deg2_ff ? 49'(deg_x) : raw2_ff[48:0];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         x3_ff <= x3_in;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[STAGES-1];
   assign out_x     = x3_ff;

endmodule

// ===== hdl/scu_reduce.sv =====
module scu_reduce (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  scu_pkg::rad_type      in_x,
   output logic                  out_valid,
   input  logic                  out_ready,
   output scu_pkg::red_word_type out_word
);
   import scu_pkg::*;

   localparam int STAGES = 6;
   localparam logic signed [14:0] Recip       = 15'(RECIP_TWO_PI);
   localparam logic signed [35:0] TwoPiS      = 36'(TWO_PI_Q32);
   localparam logic signed [36:0] TwoPiR      = 37'(TWO_PI_Q32);
   localparam logic [34:0]        TwoPiU      = 35'(TWO_PI_Q32);
   localparam logic [34:0]        PiU         = 35'(PI_Q32);
   localparam logic [34:0]        HalfPiU     = 35'(HALF_PI_Q32);
   localparam logic [34:0]        ThreeHalfPi = 35'(THREE_HALF_PI_Q32);
   localparam logic [32:0]        HalfPiMag   = 33'(HALF_PI_Q32);

   logic [STAGES-1:0] v_ff, v_in, en;

   logic signed [28:0] x_hi;
   rad_type            x1_ff;
   logic signed [43:0] qp1_ff, qp1_in;

   logic signed [15:0] q_est;
   rad_type            x2_ff;
   logic signed [51:0] qt2_ff, qt2_in;

   logic signed [51:0] diff;
   logic signed [36:0] r3_ff;

   logic signed [36:0] rem_sum;
   logic [34:0]        rem4_ff;

   logic               neg5_ff, neg5_in;
   logic [32:0]        fmag5_ff, fmag5_in;

   logic [33:0]        rnd_sum;
   red_word_type       red6_ff, red6_in;

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      v_in = v_ff;
      if (en[0]) begin
         v_in[0] = in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (en[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Stage 1: estimate the turn count from the top bits of the angle
   assign x_hi   = in_x[48:20];
   assign qp1_in = x_hi * Recip;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x1_ff  <= in_x;
         qp1_ff <= qp1_in;
      end
   end

   // Stage 2: scale the estimate back to radians
   assign q_est  = qp1_ff[43:28];
   assign qt2_in = q_est * TwoPiS;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         x2_ff  <= x1_ff;
         qt2_ff <= qt2_in;
      end
   end

   // Stage 3: take the rough remainder, within one turn of the true one
   assign diff = 52'(x2_ff) - qt2_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         r3_ff <= diff[36:0];
      end
   end

   // Stage 4: correct the remainder into one turn
   assign rem_sum = r3_ff[36] ? r3_ff + TwoPiR
                  : ((r3_ff >= TwoPiR) ? r3_ff - TwoPiR : r3_ff);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         rem4_ff <= rem_sum[34:0];
      end
   end

   // Stage 5: fold into the right half plane as sign and magnitude
   always_comb begin
      priority if (rem4_ff > ThreeHalfPi) begin
         neg5_in  = 1'b1;
         fmag5_in = 33'(TwoPiU - rem4_ff);
      end else if (rem4_ff > HalfPiU) begin
         if (rem4_ff > PiU) begin
            neg5_in  = 1'b1;
            fmag5_in = 33'(rem4_ff - PiU);
         end else begin
            neg5_in  = 1'b0;
            fmag5_in = 33'(PiU - rem4_ff);
         end
      end else begin
         neg5_in  = 1'b0;
         fmag5_in = 33'(rem4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         neg5_ff  <= neg5_in;
         fmag5_ff <= fmag5_in;
      end
   end

   // Stage 6: round to Q2.30, half away from zero
   assign rnd_sum     = 34'(fmag5_ff) + 34'd2;
   assign red6_in.neg = neg5_ff;
   assign red6_in.mag = rnd_sum[32:2];

   always_ff @(posedge clock) begin
      if (en[5]) begin
         red6_ff <= red6_in;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[STAGES-1];
   assign out_word  = red6_ff;

`ifndef SYNTHESIS
   rough_rem_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] |-> (r3_ff >= -TwoPiR) && (r3_ff < TwoPiR + TwoPiR))
      else $error("turn estimate off by more than one");

   rem_in_turn: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] |-> rem4_ff < TwoPiU)
      else $error("corrected remainder outside one turn");

   fold_in_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[4] |-> fmag5_ff <= HalfPiMag)
      else $error("folded angle beyond a quarter turn");
`endif

endmodule

// ===== hdl/scu_poly.sv =====
module scu_poly (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  scu_pkg::red_word_type in_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output scu_pkg::rsp_word_type out_word
);
   import scu_pkg::*;

   localparam int STAGES = 7;
   localparam logic signed [33:0] OneS    = 34'(ONE_Q30);
   localparam logic signed [33:0] NegOneS = -OneS;
   localparam logic [30:0]        MagMax  = 31'(MAG_MAX);
   localparam value_type          OneV    = 32'(ONE_Q30);
   localparam value_type          NegOneV = -OneV;

   logic [STAGES-1:0] v_ff, v_in, en;

   // Sign, magnitude and powers along the chain
   logic               neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [30:0]        m1_ff, m2_ff, m3_ff;
   logic [31:0]        r2_1_ff, r2_2_ff, r2_3_ff, r2_4_ff;
   logic [31:0]        r2_in;
   logic [32:0]        p3_ff, p3_in;
   logic [33:0]        p5_ff, p5_in;
   logic [34:0]        p7_ff, p7_in;
   logic [35:0]        p9_ff, p9_in;
   logic [29:0]        t3_ff, t3_in;
   logic [26:0]        t5_ff, t5_in;
   logic [22:0]        t7_ff, t7_in;
   logic [17:0]        t9_ff, t9_in;
   logic signed [33:0] acc4_ff, acc4_in, acc5_ff, acc5_in, acc6_ff, acc6_in;
   logic signed [33:0] sum, sat;
   value_type          value_ff, value_in;

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      v_in = v_ff;
      if (en[0]) begin
         v_in[0] = in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (en[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Stage 1: square
   assign r2_in = 32'(mul_q30(36'(in_word.mag), 32'(in_word.mag)));

   always_ff @(posedge clock) begin
      if (en[0]) begin
         neg1_ff <= in_word.neg;
         m1_ff   <= in_word.mag;
         r2_1_ff <= r2_in;
      end
   end

   // Stage 2: cube
   assign p3_in = 33'(mul_q30(36'(m1_ff), r2_1_ff));

   always_ff @(posedge clock) begin
      if (en[1]) begin
         neg2_ff <= neg1_ff;
         m2_ff   <= m1_ff;
         r2_2_ff <= r2_1_ff;
         p3_ff   <= p3_in;
      end
   end

   // Stage 3: fifth power and cubic term
   assign p5_in = 34'(mul_q30(36'(p3_ff), r2_2_ff));
   assign t3_in = 30'(mul_q30(36'(p3_ff), 32'(C3_Q30)));

   always_ff @(posedge clock) begin
      if (en[2]) begin
         neg3_ff <= neg2_ff;
         m3_ff   <= m2_ff;
         r2_3_ff <= r2_2_ff;
         p5_ff   <= p5_in;
         t3_ff   <= t3_in;
      end
   end

   // Stage 4: seventh power, fifth-order term, start the sum
   assign p7_in   = 35'(mul_q30(36'(p5_ff), r2_3_ff));
   assign t5_in   = 27'(mul_q30(36'(p5_ff), 32'(C5_Q30)));
   assign acc4_in = 34'(m3_ff) - 34'(t3_ff);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         neg4_ff <= neg3_ff;
         r2_4_ff <= r2_3_ff;
         p7_ff   <= p7_in;
         t5_ff   <= t5_in;
         acc4_ff <= acc4_in;
      end
   end

   // Stage 5: ninth power, seventh-order term, add the fifth-order term
   assign p9_in   = 36'(mul_q30(36'(p7_ff), r2_4_ff));
   assign t7_in   = 23'(mul_q30(36'(p7_ff), 32'(C7_Q30)));
   assign acc5_in = acc4_ff + 34'(t5_ff);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         neg5_ff <= neg4_ff;
         p9_ff   <= p9_in;
         t7_ff   <= t7_in;
         acc5_ff <= acc5_in;
      end
   end

   // Stage 6: ninth-order term, subtract the seventh-order term
   assign t9_in   = 18'(mul_q30(p9_ff, 32'(C9_Q30)));
   assign acc6_in = acc5_ff - 34'(t7_ff);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         neg6_ff <= neg5_ff;
         t9_ff   <= t9_in;
         acc6_ff <= acc6_in;
      end
   end

   // Stage 7: finish the sum, clamp to one and restore the sign
   assign sum = acc6_ff + 34'(t9_ff);

   always_comb begin
      priority if (sum > OneS) begin
         sat = OneS;
      end else if (sum < NegOneS) begin
         sat = NegOneS;
      end else begin
         sat = sum;
      end
   end

   assign value_in = 32'(neg6_ff ? -sat : sat);

   always_ff @(posedge clock) begin
      if (en[6]) begin
         value_ff <= value_in;
      end
   end

   assign in_ready       = en[0];
   assign out_valid      = v_ff[STAGES-1];
   assign out_word.value = value_ff;

`ifndef SYNTHESIS
   mag_in_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] |-> m1_ff <= MagMax)
      else $error("reduced magnitude beyond a quarter turn");

   partial_sum_positive: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] |-> !acc4_ff[33])
      else $error("cubic partial sum went negative");

   value_clamped: assert property (@(posedge clock) disable iff (reset)
      v_ff[6] |-> (value_ff <= OneV) && (value_ff >= NegOneV))
      else $error("result outside plus or minus one");
`endif

endmodule

// ===== sim/tb_sine_cosine_unit.sv =====
`timescale 1ns / 1ps

module tb_sine_cosine_unit;
   import scu_pkg::*;

   // Fixed-point constants; radian angles carry 32 fraction bits
   localparam longint PI_FX            = 64'sd13493037045;
   localparam longint TWO_PI_FX        = PI_FX * 2;
   localparam longint HALF_PI_FX       = PI_FX / 2;
   localparam longint THREE_HALF_PI_FX = (PI_FX * 3) / 2;
   localparam longint DEG_SCALE_FX     = PI_FX / 180;
   localparam longint RIGHT_ANGLE_DEG  = 64'sd90 * 64'sd65536;
   localparam longint UNIT_Q30         = 64'sd1 << 30;
   localparam longint TAYLOR3          = (UNIT_Q30 + 3) / 6;
   localparam longint TAYLOR5          = (UNIT_Q30 + 60) / 120;
   localparam longint TAYLOR7          = (UNIT_Q30 + 2520) / 5040;
   localparam longint TAYLOR9          = (UNIT_Q30 + 181440) / 362880;

   localparam int ITEMS_PER_PHASE = 170;
   localparam int NUM_PHASES      = 4;
   localparam int LONG_HOLD       = 80;
   localparam int QUIET_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 24;
   localparam int NUM_PROBES      = 24;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      opcode_type opcode;
      angle_type  angle;
      logic       pinned;
      value_type  value;
   } probe_row_type;

   typedef struct {
      opcode_type opcode;
      angle_type  angle;
      value_type  value;
   } pending_value_type;

   // Directed words; pinned rows carry their result, the rest go through the predictor
   probe_row_type probe_rows [NUM_PROBES] = '{
      '{OP_SIN_RAD, 32'sd0,          1'b1, 32'sd0},
      '{OP_COS_RAD, 32'sd0,          1'b0, 32'sd0},
      '{OP_SIN_DEG, 32'sd0,          1'b1, 32'sd0},
      '{OP_COS_DEG, 32'sd0,          1'b0, 32'sd0},
      '{OP_COS_DEG, -32'sd5898240,   1'b1, 32'sd0},
      '{OP_SIN_RAD, 32'sh7FFFFFFF,   1'b0, 32'sd0},
      '{OP_COS_RAD, 32'sh7FFFFFFF,   1'b0, 32'sd0},
      '{OP_SIN_DEG, 32'sh7FFFFFFF,   1'b0, 32'sd0},
      '{OP_COS_DEG, 32'sh7FFFFFFF,   1'b0, 32'sd0},
      '{OP_SIN_RAD, 32'sh80000000,   1'b0, 32'sd0},
      '{OP_COS_RAD, 32'sh80000000,   1'b0, 32'sd0},
      '{OP_SIN_DEG, 32'sh80000000,   1'b0, 32'sd0},
      '{OP_COS_DEG, 32'sh80000000,   1'b0, 32'sd0},
      '{OP_SIN_RAD, 32'sd1,          1'b0, 32'sd0},
      '{OP_SIN_RAD, -32'sd1,         1'b0, 32'sd0},
      '{OP_SIN_RAD, 32'sd102944,     1'b0, 32'sd0},
      '{OP_SIN_RAD, 32'sd205887,     1'b0, 32'sd0},
      '{OP_SIN_RAD, 32'sd308831,     1'b0, 32'sd0},
      '{OP_SIN_RAD, -32'sd102944,    1'b0, 32'sd0},
      '{OP_COS_RAD, 32'sd205887,     1'b0, 32'sd0},
      '{OP_SIN_DEG, 32'sd5898240,    1'b0, 32'sd0},
      '{OP_SIN_DEG, 32'sd17694720,   1'b0, 32'sd0},
      '{OP_SIN_DEG, -32'sd5898240,   1'b0, 32'sd0},
      '{OP_COS_DEG, 32'sd11796480,   1'b0, 32'sd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   scu_if #(.word_type(req_word_type)) req_chan ();
   scu_if #(.word_type(rsp_word_type)) rsp_chan ();

   sine_cosine_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pending_value_type pending_values [$];
   int mismatches     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_orders    = 0;
   int quiet_cycles   = 0;

   always #1 clock = ~clock;

   // Shift right with rounding half away from zero
   function automatic longint round_shift(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (s - 1))) >>> s;
      return (v < 0) ? -m : m;
   endfunction

   // Q2.30 product, rounded half away from zero on the magnitude
   function automatic longint q30_product(longint a, longint b);
      logic [127:0] p;
      longint       m;
      p = 128'((a < 0) ? -a : a) * 128'((b < 0) ? -b : b) + (128'd1 << 29);
      p = p >> 30;
      m = longint'(p[63:0]);
      return ((a < 0) != (b < 0)) ? -m : m;
   endfunction

   function automatic value_type predict_sine_cosine(opcode_type op, angle_type ang);
      logic   is_cos;
      logic   is_deg;
      longint arg;
      longint rad;
      longint r;
      longint r2;
      longint pw;
      longint acc;
      is_cos = (op == OP_COS_RAD) || (op == OP_COS_DEG);
      is_deg = (op == OP_SIN_DEG) || (op == OP_COS_DEG);
      arg = longint'(ang);
      // widen to radians, adding a quarter turn for cosine
      if (is_deg) begin
         if (is_cos) arg = arg + RIGHT_ANGLE_DEG;
         rad = round_shift(arg * DEG_SCALE_FX, 16);
      end else begin
         rad = arg * 65536;
         if (is_cos) rad = rad + HALF_PI_FX;
      end
      // fold into [-pi/2, pi/2]
      rad = rad - (rad / TWO_PI_FX) * TWO_PI_FX;
      if (rad < 0) rad = rad + TWO_PI_FX;
      if (rad > THREE_HALF_PI_FX) rad = rad - TWO_PI_FX;
      else if (rad > HALF_PI_FX) rad = PI_FX - rad;
      // odd Taylor series through x^9, then saturate
      r   = round_shift(rad, 2);
      r2  = q30_product(r, r);
      pw  = q30_product(r2, r);
      acc = r - q30_product(pw, TAYLOR3);
      pw  = q30_product(pw, r2);
      acc = acc + q30_product(pw, TAYLOR5);
      pw  = q30_product(pw, r2);
      acc = acc - q30_product(pw, TAYLOR7);
      pw  = q30_product(pw, r2);
      acc = acc + q30_product(pw, TAYLOR9);
      if (acc > UNIT_Q30) acc = UNIT_Q30;
      if (acc < -UNIT_Q30) acc = -UNIT_Q30;
      return value_type'(acc);
   endfunction

   // Mix full-range angles, angles within 400 degrees or 7 radians of zero and angles near quarter turns
   function automatic angle_type random_angle(opcode_type op);
      int     pick;
      longint k;
      longint base;
      pick = $urandom_range(99);
      k    = longint'($urandom_range(16)) - 8;
      if (pick < 40) begin
         return angle_type'($urandom);
      end else if (pick < 75) begin
         if (op == OP_SIN_DEG || op == OP_COS_DEG)
            return angle_type'(longint'($urandom_range(800 * 65536)) - 400 * 65536);
         return angle_type'(longint'($urandom_range(14 * 65536)) - 7 * 65536);
      end else begin
         if (op == OP_SIN_DEG || op == OP_COS_DEG) base = k * RIGHT_ANGLE_DEG;
         else base = (k * HALF_PI_FX) / 65536;
         return angle_type'(base + longint'($urandom_range(8)) - 4);
      end
   endfunction

   // Offer one word, idling first at the phase rate, and log its expected value
   task automatic send_angle(opcode_type op, angle_type ang, logic pinned,
                             value_type pinned_value);
      pending_value_type entry;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.word  <= '{opcode: op, angle: ang};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      entry.opcode = op;
      entry.angle  = ang;
      entry.value  = pinned ? pinned_value : predict_sine_cosine(op, ang);
      pending_values.push_back(entry);
      @(negedge clock);
   endtask

   // Hold the sender until every expected word has come back
   task automatic drain_pending();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_values.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls at the phase rate, long holds on request
   initial begin
      int hold_left;
      int hold_served;
      hold_left   = 0;
      hold_served = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_served != hold_orders) begin
            hold_served = hold_orders;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Check each returned word against the oldest expectation
   always @(posedge clock) begin
      pending_value_type entry;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_values.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected word: value %0d", rsp_chan.word.value);
         end else begin
            entry = pending_values.pop_front();
            if (rsp_chan.word.value !== entry.value) begin
               mismatches = mismatches + 1;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch: opcode %0d angle %0d expected %0d got %0d",
                           entry.opcode, entry.angle, entry.value, rsp_chan.word.value);
            end
         end
      end
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      opcode_type op;
      req_chan.valid = 1'b0;
      req_chan.word  = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words, no idling
      for (int i = 0; i < NUM_PROBES; i++)
         send_angle(probe_rows[i].opcode, probe_rows[i].angle,
                    probe_rows[i].pinned, probe_rows[i].value);
      drain_pending();

      // random phases: none, sender idle, receiver stall, both
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         // in the first phase, fill the pipe against a long receiver hold
         if (phase == 0) hold_orders = hold_orders + 1;
         @(negedge clock);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            op = opcode_type'($urandom_range(OP_COS_DEG));
            send_angle(op, random_angle(op), 1'b0, '0);
         end
         drain_pending();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_values.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
